// ===== rtl/core/shabs_pkg.sv =====
// Shared types and constant tables for the SHA-256 byte stream hasher.
package shabs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] work_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_req_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/core/shabs_ram.sv =====
// Generic simple dual-port RAM with registered read.
module shabs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/shabs_round.sv =====
// One SHA-256 compression round and one message schedule step.
module shabs_round (
  input  shabs_pkg::work_t cur,
  input  shabs_pkg::word_t kw,
  input  shabs_pkg::word_t w0,
  input  shabs_pkg::word_t w1,
  input  shabs_pkg::word_t w9,
  input  shabs_pkg::word_t w14,
  output shabs_pkg::work_t nxt,
  output shabs_pkg::word_t wnew
);

  function automatic shabs_pkg::word_t rotr(input shabs_pkg::word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  shabs_pkg::word_t big0, big1, choose, major, x1, x2, sig0, sig1;

  always_comb begin
    big1   = rotr(cur[4], 6) ^ rotr(cur[4], 11) ^ rotr(cur[4], 25);
    choose = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
    big0   = rotr(cur[0], 2) ^ rotr(cur[0], 13) ^ rotr(cur[0], 22);
    major  = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
    x1     = cur[7] + big1 + choose + kw + w0;
    x2     = big0 + major;
    nxt[7] = cur[6];
    nxt[6] = cur[5];
    nxt[5] = cur[4];
    nxt[4] = cur[3] + x1;
    nxt[3] = cur[2];
    nxt[2] = cur[1];
    nxt[1] = cur[0];
    nxt[0] = x1 + x2;
    sig0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    sig1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    wnew   = sig1 + w9 + sig0 + w0;
  end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher top level: intake, padding, compression sequencer, digest output.
// A request is taken whenever the hasher is idle; a byte that completes a 64-byte block
// adds a compression (block load, rounds, hash write-back) run by the sequencer.
// Message end adds up to 18 padding writes, one or two compressions, a read and a capture
// per digest word and a hash reload; input stalls throughout.
// Synchronous active-low reset runs the hash reload before the first request.
module sha256_byte_stream_hasher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  shabs_pkg::in_req_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output shabs_pkg::out_req_t out_data
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_ROUND = 4'd3;
  localparam logic [3:0] ST_UPD   = 4'd4;
  localparam logic [3:0] ST_FIN   = 4'd5;
  localparam logic [3:0] ST_PAD   = 4'd6;
  localparam logic [3:0] ST_EMRD  = 4'd7;
  localparam logic [3:0] ST_EMCAP = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [3:0]          ret_r, ret_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [5:0]          fill_r, fill_nxt;
  logic [23:0]         part_r, part_nxt;
  logic [54:0]         blk_r, blk_nxt;
  logic [3:0]          pad_r, pad_nxt;
  logic                extra_r, extra_nxt;
  shabs_pkg::work_t    work_r, work_nxt;
  shabs_pkg::word_t    win_r [16];
  shabs_pkg::word_t    win_nxt [16];
  logic                out_valid_r, out_valid_nxt;
  shabs_pkg::out_req_t out_data_r, out_data_nxt;

  logic             h_we;
  logic [2:0]       h_waddr, h_raddr;
  shabs_pkg::word_t h_wdata, h_rdata;
  logic             b_we;
  logic [3:0]       b_waddr, b_raddr;
  shabs_pkg::word_t b_wdata, b_rdata;

  shabs_pkg::work_t rnd_nxt;
  shabs_pkg::word_t wnew;
  logic             out_take;
  logic [63:0]      total_bits;
  logic [3:0]       fin_idx;

  shabs_ram #(.WIDTH(32), .DEPTH(8)) u_hash_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  shabs_ram #(.WIDTH(32), .DEPTH(16)) u_block_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  shabs_round u_round (
    .cur  (work_r),
    .kw   (shabs_pkg::K_TABLE[cnt_r]),
    .w0   (win_r[0]),
    .w1   (win_r[1]),
    .w9   (win_r[9]),
    .w14  (win_r[14]),
    .nxt  (rnd_nxt),
    .wnew (wnew)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_take   = out_valid_r && !out_stall;
  assign total_bits = {blk_r, fill_r, 3'b000};
  assign fin_idx    = fill_r[5:2];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    part_nxt      = part_r;
    blk_nxt       = blk_r;
    pad_nxt       = pad_r;
    extra_nxt     = extra_r;
    work_nxt      = work_r;
    win_nxt       = win_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    h_we          = 1'b0;
    h_waddr       = cnt_r[2:0];
    h_wdata       = '0;
    h_raddr       = cnt_r[2:0];
    b_we          = 1'b0;
    b_waddr       = pad_r;
    b_wdata       = '0;
    b_raddr       = cnt_r[3:0];

    unique case (state_r)
      ST_INIT: begin
        h_we     = 1'b1;
        h_wdata  = shabs_pkg::H_INIT[cnt_r[2:0]];
        fill_nxt = '0;
        blk_nxt  = '0;
        if (cnt_r[2:0] == 3'd7) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_present) begin
            case (fill_r[1:0])
              2'd0: part_nxt[23:16] = in_data.data_byte;
              2'd1: part_nxt[15:8]  = in_data.data_byte;
              2'd2: part_nxt[7:0]   = in_data.data_byte;
              default: begin
                b_we    = 1'b1;
                b_waddr = fill_r[5:2];
                b_wdata = {part_r, in_data.data_byte};
              end
            endcase
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              blk_nxt   = blk_r + 55'd1;
              state_nxt = ST_LOAD;
              cnt_nxt   = '0;
              ret_nxt   = in_data.message_end ? ST_FIN : ST_IDLE;
            end else if (in_data.message_end) begin
              state_nxt = ST_FIN;
            end
          end else if (in_data.message_end) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        b_we    = 1'b1;
        b_waddr = fin_idx;
        case (fill_r[1:0])
          2'd0:    b_wdata = {8'h80, 24'h0};
          2'd1:    b_wdata = {part_r[23:16], 8'h80, 16'h0};
          2'd2:    b_wdata = {part_r[23:8], 8'h80, 8'h0};
          default: b_wdata = {part_r, 8'h80};
        endcase
        if (fin_idx == 4'd15) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
          ret_nxt   = ST_PAD;
          pad_nxt   = '0;
          extra_nxt = 1'b0;
        end else begin
          state_nxt = ST_PAD;
          pad_nxt   = fin_idx + 4'd1;
          extra_nxt = (fill_r[5:3] == 3'b111);
        end
      end
      ST_PAD: begin
        b_we    = 1'b1;
        b_waddr = pad_r;
        if (extra_r) begin
          b_wdata = '0;
        end else if (pad_r == 4'd14) begin
          b_wdata = total_bits[63:32];
        end else if (pad_r == 4'd15) begin
          b_wdata = total_bits[31:0];
        end else begin
          b_wdata = '0;
        end
        pad_nxt = pad_r + 4'd1;
        if (pad_r == 4'd15) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
          extra_nxt = 1'b0;
          ret_nxt   = extra_r ? ST_PAD : ST_EMRD;
        end
      end
      ST_LOAD: begin
        if (cnt_r >= 6'd1 && cnt_r <= 6'd8) begin
          work_nxt = {h_rdata, work_r[7:1]};
        end
        if (cnt_r >= 6'd1) begin
          for (int i = 0; i < 15; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[15] = b_rdata;
        end
        if (cnt_r == 6'd16) begin
          state_nxt = ST_ROUND;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_ROUND: begin
        work_nxt = rnd_nxt;
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[15] = wnew;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_UPD;
          cnt_nxt   = '0;
        end
      end
      ST_UPD: begin
        if (cnt_r >= 6'd1) begin
          h_we     = 1'b1;
          h_waddr  = cnt_r[2:0] - 3'd1;
          h_wdata  = h_rdata + work_r[0];
          work_nxt = {work_r[0], work_r[7:1]};
        end
        if (cnt_r == 6'd8) begin
          state_nxt = ret_r;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_EMRD: begin
        if (!out_valid_r || out_take) begin
          state_nxt = ST_EMCAP;
        end
      end
      ST_EMCAP: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.digest_word = h_rdata;
        out_data_nxt.word_index  = cnt_r[2:0];
        out_data_nxt.last_word   = (cnt_r[2:0] == 3'd7);
        if (cnt_r[2:0] == 3'd7) begin
          state_nxt = ST_INIT;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_EMRD;
          cnt_nxt   = cnt_r + 6'd1;
        end
      end
      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ret_r       <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      blk_r       <= '0;
      pad_r       <= '0;
      extra_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      blk_r       <= blk_nxt;
      pad_r       <= pad_nxt;
      extra_r     <= extra_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r     <= part_nxt;
    work_r     <= work_nxt;
    win_r      <= win_nxt;
    out_data_r <= out_data_nxt;
  end

  a_rise_from_capture: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMCAP)
    else $error("digest word presented outside capture");

  a_rounds_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && cnt_r == 6'd63) |=> state_r == ST_UPD)
    else $error("round sequence did not end in hash update");

  a_last_is_seventh: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_word) |-> out_data_r.word_index == 3'd7)
    else $error("last word flag on wrong digest word");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> cnt_r <= 6'd16)
    else $error("load counter overran");

endmodule

// ===== test/sha256_byte_stream_hasher_tb.sv =====
// Testbench for the SHA-256 byte stream hasher: random messages checked against a digest predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int N_ITEMS = 380;
  localparam int LONG_HOLD = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int EDGE_LENS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    shabs_pkg::in_req_t req;
    bit                 drain;
  } pending_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  shabs_pkg::in_req_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  shabs_pkg::out_req_t out_data;

  pending_t            request_q [$];
  shabs_pkg::out_req_t digest_q [$];

  logic [31:0] hv [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] nbits;

  bit calm = 1'b0;
  int n_items = 0;
  int n_taken = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit held_long = 1'b0;
  int words_seen = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  sha256_byte_stream_hasher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hv[i] = IV[i];
    fill = '0;
    nbits = '0;
  endtask

  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) r[i] = hv[i];
    for (int t = 0; t < 64; t++) begin
      t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RK[t] + w[t];
      t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      for (int i = 7; i > 0; i--) r[i] = r[i-1];
      r[4] = r[4] + t1;
      r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] = hv[i] + r[i];
  endtask

  task automatic absorb_request(input shabs_pkg::in_req_t q);
    logic [63:0] total;
    int p;
    shabs_pkg::out_req_t want;
    if (q.byte_present) begin
      blk[fill] = q.data_byte;
      fill = fill + 6'd1;
      if (fill == 6'd0) begin
        sha_compress();
        nbits = nbits + 64'd512;
      end
    end
    if (q.message_end) begin
      p = int'(fill);
      total = nbits + 64'(p) * 64'd8;
      blk[p] = 8'h80;
      p++;
      if (p > 56) begin
        while (p < 64) blk[p++] = 8'h00;
        sha_compress();
        p = 0;
      end
      while (p < 56) blk[p++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        want.digest_word = hv[i];
        want.word_index = 3'(i);
        want.last_word = (i == 7);
        digest_q.push_back(want);
      end
      restart_digest();
    end
  endtask

  task automatic queue_request(input logic [7:0] b, input bit has_byte, input bit fin,
                               input bit drain);
    pending_t e;
    e.req.data_byte = b;
    e.req.byte_present = has_byte;
    e.req.message_end = fin;
    e.drain = drain;
    request_q.push_back(e);
    if (has_byte || fin) n_items++;
  endtask

  task automatic queue_message(input int len, input bit drain);
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) queue_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      queue_request(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == len - 1),
                    drain && (k == 0));
    end
    if (!end_on_byte) queue_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
  endtask

  task automatic flag_mismatch(input string msg);
    if (err_cnt < 100) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // sender
  always @(posedge clk) begin
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_request(in_data);
        n_taken++;
      end
      calm <= (request_q.size() < 60) || ((n_taken / 50) % 3 == 2);
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() == 0 || (request_q[0].drain && digest_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          nxt = request_q.pop_front();
          in_data <= nxt.req;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    shabs_pkg::out_req_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected digest word %h idx %0d", out_data.digest_word,
                                  out_data.word_index));
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word)
            flag_mismatch($sformatf("digest_word %h, want %h (idx %0d)", out_data.digest_word,
                                    want.digest_word, want.word_index));
          if (out_data.word_index !== want.word_index)
            flag_mismatch($sformatf("word_index %0d, want %0d", out_data.word_index,
                                    want.word_index));
          if (out_data.last_word !== want.last_word)
            flag_mismatch($sformatf("last_word %b, want %b (idx %0d)", out_data.last_word,
                                    want.last_word, want.word_index));
        end
        words_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_long && out_valid && words_seen >= 48) begin
        held_long = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR @%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    bit first;
    int pick;
    int len;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    restart_digest();

    // empty message, ignored request, "abc", single bytes 00 and ff, two-byte and empty messages
    queue_request(8'h00, 1'b0, 1'b1, 1'b0);
    queue_request(8'hff, 1'b0, 1'b0, 1'b0);
    queue_request(8'h61, 1'b1, 1'b0, 1'b0);
    queue_request(8'h62, 1'b1, 1'b0, 1'b0);
    queue_request(8'h63, 1'b1, 1'b1, 1'b0);
    queue_request(8'h00, 1'b1, 1'b1, 1'b0);
    queue_request(8'hff, 1'b1, 1'b1, 1'b0);
    queue_request(8'hff, 1'b1, 1'b0, 1'b0);
    queue_request(8'h5a, 1'b0, 1'b0, 1'b0);
    queue_request(8'h00, 1'b1, 1'b0, 1'b0);
    queue_request(8'ha5, 1'b0, 1'b1, 1'b0);
    queue_request(8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(8'h3c, 1'b0, 1'b1, 1'b0);

    first = 1'b1;
    while (n_items < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(0, 12);
      else if (pick < 85) len = EDGE_LENS[$urandom_range(0, 8)];
      else len = $urandom_range(13, 140);
      queue_message(len, first || ($urandom_range(0, 5) == 0));
      first = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (request_q.size() > 0 || in_valid || digest_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/shabs_pkg.sv
rtl/core/shabs_ram.sv
rtl/core/shabs_round.sv
rtl/core/sha256_byte_stream_hasher.sv
test/sha256_byte_stream_hasher_tb.sv
